[hdl/mma_pkg.sv]
// Shared constants and types for the per-channel moving-average filter.
// No dependencies; imported by multichannel_moving_average and tb_top.
package mma_pkg;

   // Block configuration
   localparam int CHANNELS    = 32;
   localparam int WINDOW      = 5;
   localparam int SAMPLE_BITS = 12;

   // Field widths of the stream items
   localparam int CHAN_BITS = 5;
   localparam int DATA_BITS = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;

   // Derived storage widths
   localparam int SLOT_BITS      = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int SUM_BITS       = SAMPLE_BITS + $clog2(WINDOW);
   localparam int SAMP_DEPTH     = CHANNELS * WINDOW;
   localparam int SAMP_ADDR_BITS = $clog2(SAMP_DEPTH);

   // Divide by WINDOW as multiply by rounded-up reciprocal and shift
   localparam int DIV_SHIFT = SUM_BITS + $clog2(WINDOW);
   localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int MULT_BITS = SUM_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + MULT_BITS;

   // Per-channel write position and whether the window has been filled once
   typedef struct packed {
      logic                 wrapped;
      logic [SLOT_BITS-1:0] slot;
   } slot_state_type;

endpackage

[hdl/multichannel_moving_average.sv]
// Per-channel moving-average filter: top level with its state memories.
// Depends on mma_pkg.
//
// Usage:
//  req_ channel: one item per converter sample, carrying a channel number and a
//  12-bit reading. rsp_ channel: one item per input item, in order, carrying the
//  channel number and the mean of that channel's last five samples, truncated.
//  Both channels accept an item when tvalid and tready are high at a clock edge.
//  rsp_tvalid rises when the item reaches the output register. Throughput is
//  one item per cycle while rsp_tready is high: stage 1 updates slot and
//  sample, stage 2 the running sum, stage 3 divides and stage 4 is the output
//  register, each stage moving as soon as the one after it is free. Samples sit
//  in one memory, the write slot and the running sum in two small ones;
//  back-to-back items on the same channel are forwarded from the next stage.
//  Reset clears the per-channel valid flags: an unwritten channel reads as
//  slot zero, sum zero and an empty window, so the first averages include
//  zeros. No clearing pass is needed and the block is ready straight
//  after reset. When the receiver stalls the result is held; the stages behind
//  it keep filling, and req_tready falls once all four are occupied.
//  A channel number at or above the channel count changes no state and returns
//  an average of zero.
module multichannel_moving_average (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] channel, [16:5] sample, rest zero
   input  logic [mma_pkg::DATA_BITS-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [4:0] channel_out, [16:5] average, rest zero
   output logic [mma_pkg::DATA_BITS-1:0]  rsp_tdata
);
   import mma_pkg::*;

   // Memories
   slot_state_type                slot_mem [CHANNELS];
   logic [SUM_BITS-1:0]           sum_mem  [CHANNELS];
   logic [SAMPLE_BITS-1:0]        samp_mem [SAMP_DEPTH];

   // Per-channel valid flags (cleared at reset)
   logic [CHANNELS-1:0] slot_valid_ff, slot_valid_in;
   logic [CHANNELS-1:0] sum_valid_ff,  sum_valid_in;

   // Stage 1: slot lookup, sample write
   logic                   s1_valid_ff, s1_valid_in;
   logic [CHAN_BITS-1:0]   s1_ch_ff;
   logic [SAMPLE_BITS-1:0] s1_smp_ff;
   logic                   s1_range_ff;
   slot_state_type         s1_slot_rd_ff;

   // Stage 2: old sample and sum arrive
   logic                   s2_valid_ff, s2_valid_in;
   logic [CHAN_BITS-1:0]   s2_ch_ff;
   logic [SAMPLE_BITS-1:0] s2_smp_ff;
   logic                   s2_range_ff;
   logic                   s2_wrapped_ff;
   slot_state_type         s2_next_ff;
   logic [SAMPLE_BITS-1:0] s2_old_rd_ff;
   logic [SUM_BITS-1:0]    s2_sum_rd_ff;

   // Stage 3: new sum
   logic                   s3_valid_ff, s3_valid_in;
   logic [CHAN_BITS-1:0]   s3_ch_ff;
   logic                   s3_range_ff;
   logic [SUM_BITS-1:0]    s3_sum_ff;

   // Stage 4: output register
   logic                   s4_valid_ff, s4_valid_in;
   logic [CHAN_BITS-1:0]   s4_ch_ff;
   logic [SAMPLE_BITS-1:0] s4_avg_ff;

   // Handshake and stage movement
   logic                   req_fire;
   logic                   s4_free, s3_free, s2_free, s1_free;
   logic                   s1_move, s2_move, s3_move;
   logic [CHAN_BITS-1:0]   req_ch;
   logic [SAMPLE_BITS-1:0] req_smp;

   // Stage 1 working signals
   logic                      s1_fwd;
   slot_state_type            s1_cur;
   slot_state_type            s1_next;
   logic [SAMP_ADDR_BITS-1:0] s1_addr;

   // Stage 2 working signals
   logic                   s2_fwd;
   logic [SUM_BITS-1:0]    s2_sum_cur;
   logic [SAMPLE_BITS-1:0] s2_old;
   logic [SUM_BITS-1:0]    s2_sum_new;

   // Stage 3 working signals
   logic [PROD_BITS-1:0]   s3_prod;
   logic [SAMPLE_BITS-1:0] s3_avg;

   assign req_ch  = req_tdata[CHAN_BITS-1:0];
   assign req_smp = req_tdata[CHAN_BITS +: SAMPLE_BITS];

   // A stage moves when the next one is empty or moving
   assign s4_free    = !s4_valid_ff || rsp_tready;
   assign s3_move    = s3_valid_ff && s4_free;
   assign s3_free    = !s3_valid_ff || s4_free;
   assign s2_move    = s2_valid_ff && s3_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_move    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move  || (s2_valid_ff && !s2_move);
   assign s3_valid_in = s2_move  || (s3_valid_ff && !s3_move);
   assign s4_valid_in = s3_move  || (s4_valid_ff && !rsp_tready);

   // Stage 1: current slot, forwarded from the item just ahead on the same channel
   always_comb begin
      s1_fwd = s2_valid_ff && s2_range_ff && (s2_ch_ff == s1_ch_ff);
      if (s1_fwd) begin
         s1_cur = s2_next_ff;
      end else if (slot_valid_ff[s1_ch_ff]) begin
         s1_cur = s1_slot_rd_ff;
      end else begin
         s1_cur = '0;
      end
      if (32'(s1_cur.slot) >= WINDOW) begin
         s1_cur.slot = '0;
      end
      s1_next.wrapped = s1_cur.wrapped;
      s1_next.slot    = s1_cur.slot + SLOT_BITS'(1);
      if (32'(s1_cur.slot) == WINDOW - 1) begin
         s1_next.wrapped = 1'b1;
         s1_next.slot    = '0;
      end
      s1_addr = SAMP_ADDR_BITS'(32'(s1_ch_ff) * WINDOW + 32'(s1_cur.slot));
   end

   // Stage 2: running sum update; the old sample counts only once the window has wrapped
   always_comb begin
      s2_fwd = s3_valid_ff && s3_range_ff && (s3_ch_ff == s2_ch_ff);
      if (s2_fwd) begin
         s2_sum_cur = s3_sum_ff;
      end else if (sum_valid_ff[s2_ch_ff]) begin
         s2_sum_cur = s2_sum_rd_ff;
      end else begin
         s2_sum_cur = '0;
      end
      s2_old     = s2_wrapped_ff ? s2_old_rd_ff : '0;
      s2_sum_new = s2_sum_cur - SUM_BITS'(s2_old) + SUM_BITS'(s2_smp_ff);
   end

   // Stage 3: divide by the window length
   assign s3_prod = PROD_BITS'(s3_sum_ff) * PROD_BITS'(DIV_MULT);
   assign s3_avg  = s3_range_ff ? s3_prod[DIV_SHIFT +: SAMPLE_BITS] : '0;

   // Valid flag updates
   always_comb begin
      slot_valid_in = slot_valid_ff;
      sum_valid_in  = sum_valid_ff;
      if (s1_move && s1_range_ff) begin
         slot_valid_in[s1_ch_ff] = 1'b1;
      end
      if (s2_move && s2_range_ff) begin
         sum_valid_in[s2_ch_ff] = 1'b1;
      end
   end

   // Slot memory: read on acceptance, written from stage 1
   always_ff @(posedge clock) begin
      if (s1_move && s1_range_ff) begin
         slot_mem[s1_ch_ff] <= s1_next;
      end
      if (req_fire) begin
         s1_slot_rd_ff <= slot_mem[req_ch];
      end
   end

   // Sample memory: old sample read and new one written at the same entry
   always_ff @(posedge clock) begin
      if (s1_move && s1_range_ff) begin
         samp_mem[s1_addr] <= s1_smp_ff;
      end
      if (s1_move) begin
         s2_old_rd_ff <= samp_mem[s1_addr];
      end
   end

   // Sum memory: read as an item enters stage 2, written from stage 2
   always_ff @(posedge clock) begin
      if (s2_move && s2_range_ff) begin
         sum_mem[s2_ch_ff] <= s2_sum_new;
      end
      if (s1_move) begin
         s2_sum_rd_ff <= sum_mem[s1_ch_ff];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
         sum_valid_ff  <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         s4_valid_ff   <= s4_valid_in;
         slot_valid_ff <= slot_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ch_ff    <= req_ch;
         s1_smp_ff   <= req_smp;
         s1_range_ff <= 32'(req_ch) < CHANNELS;
      end
      if (s1_move) begin
         s2_ch_ff      <= s1_ch_ff;
         s2_smp_ff     <= s1_smp_ff;
         s2_range_ff   <= s1_range_ff;
         s2_wrapped_ff <= s1_cur.wrapped;
         s2_next_ff    <= s1_next;
      end
      if (s2_move) begin
         s3_ch_ff    <= s2_ch_ff;
         s3_range_ff <= s2_range_ff;
         s3_sum_ff   <= s2_range_ff ? s2_sum_new : '0;
      end
      if (s3_move) begin
         s4_ch_ff  <= s3_ch_ff;
         s4_avg_ff <= s3_avg;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {(DATA_BITS - CHAN_BITS - SAMPLE_BITS)'(0), s4_avg_ff, s4_ch_ff};

   // Checks
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (32'(s1_next.slot) < WINDOW))
      else $error("write slot left the window");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (32'(s3_sum_ff) <= WINDOW * ((2 ** SAMPLE_BITS) - 1)))
      else $error("running sum beyond window capacity");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost before stage 1");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !rsp_tready) |=> (s4_valid_ff && !$past(s3_move)))
      else $error("stage 3 overwrote a held result");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for multichannel_moving_average.
// Drives random and directed samples and checks each average against a per-channel model.
// Depends on mma_pkg and the multichannel_moving_average RTL.
module tb_top;
   import mma_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 8;
   localparam int PAD_BITS     = DATA_BITS - CHAN_BITS - SAMPLE_BITS;

   typedef struct packed {
      logic [CHAN_BITS-1:0]   channel;
      logic [SAMPLE_BITS-1:0] average;
   } average_item_type;

   // Per-channel window model and the queue of averages still to arrive
   class average_scoreboard;
      logic [SAMPLE_BITS-1:0] window_mem [CHANNELS][WINDOW];
      int unsigned            next_slot [CHANNELS];
      logic [SUM_BITS-1:0]    window_total [CHANNELS];
      average_item_type       expected_averages [$];
      int                     errors;

      function new();
         foreach (window_mem[c, s]) window_mem[c][s] = '0;
         foreach (next_slot[c]) begin
            next_slot[c]    = 0;
            window_total[c] = '0;
         end
         errors = 0;
      endfunction

      // Update the channel's window with an accepted sample and queue its average
      function void note_sample(logic [CHAN_BITS-1:0] chan, logic [SAMPLE_BITS-1:0] smp);
         average_item_type predicted;
         int unsigned      slot;
         predicted.channel = chan;
         predicted.average = '0;
         if (chan < CHANNELS) begin
            slot = next_slot[chan];
            if (slot >= WINDOW) slot = 0;
            window_total[chan] = window_total[chan] - window_mem[chan][slot] + smp;
            window_mem[chan][slot] = smp;
            next_slot[chan] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            predicted.average = SAMPLE_BITS'(window_total[chan] / WINDOW);
         end
         expected_averages.push_back(predicted);
      endfunction

      // Compare a received item with the oldest queued average
      function void check_average(logic [DATA_BITS-1:0] data);
         average_item_type predicted;
         logic [CHAN_BITS-1:0]   got_channel;
         logic [SAMPLE_BITS-1:0] got_average;
         got_channel = data[CHAN_BITS-1:0];
         got_average = data[CHAN_BITS +: SAMPLE_BITS];
         if (expected_averages.size() == 0) begin
            $error("unexpected result: channel_out %0d, average %0d", got_channel, got_average);
            errors++;
         end else begin
            predicted = expected_averages.pop_front();
            if (got_channel !== predicted.channel) begin
               $error("channel_out: expected %0d, actual %0d", predicted.channel, got_channel);
               errors++;
            end
            if (got_average !== predicted.average) begin
               $error("average: expected %0d, actual %0d", predicted.average, got_average);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;

   average_scoreboard sb;
   int                idle_cycles = 0;
   int                stall_count = 0;
   int unsigned       stall_mode  = 0;

   multichannel_moving_average DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Present one sample and hold it until the block takes it
   task automatic send_sample(input logic [CHAN_BITS-1:0] chan,
                              input logic [SAMPLE_BITS-1:0] smp);
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_BITS{1'b0}}, smp, chan};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(chan, smp);
   endtask

   // Gap between bursts; a zero-length gap keeps tvalid high
   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Receiver: check results; tready follows a stall pattern re-picked when stall_count[7:0] wraps
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_average(rsp_tdata);
      stall_count <= stall_count + 1;
      if (stall_count[7:0] == 8'hFF) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(1, 0));
         2: rsp_tready <= (stall_count[2:0] < 3'd5);
         default: rsp_tready <= (stall_count[3:0] == 4'd0);
      endcase
   end

   // Watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** multichannel_moving_average: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned            sent;
      int unsigned            burst_len;
      int unsigned            burst_kind;
      logic [CHAN_BITS-1:0]   hot_a;
      logic [CHAN_BITS-1:0]   hot_b;
      logic [CHAN_BITS-1:0]   chan;
      logic [SAMPLE_BITS-1:0] smp;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale fill of one channel, window wrap, back-to-back same channel
      for (int i = 0; i < WINDOW; i++) send_sample(5'd0, 12'hFFF);
      send_sample(5'd0, 12'h000);
      send_sample(5'd0, 12'h000);
      // Top channel, alternating extremes
      send_sample(5'd31, 12'hFFF);
      send_sample(5'd31, 12'h000);
      send_sample(5'd31, 12'hFFF);
      // Alternating bit patterns on channel and sample
      send_sample(5'd10, 12'hAAA);
      send_sample(5'd21, 12'h555);
      send_sample(5'd10, 12'h555);
      send_sample(5'd21, 12'hAAA);
      send_sample(5'd31, 12'h001);
      send_sample(5'd0, 12'hFFE);
      send_sample(5'd5, 12'h000);
      pause_sender(4);

      // Random bursts: spread channels, one repeated channel, or two interleaved
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len  = $urandom_range(60, 1);
         burst_kind = $urandom_range(3, 0);
         hot_a      = CHAN_BITS'($urandom_range(31, 0));
         hot_b      = CHAN_BITS'($urandom_range(31, 0));
         for (int i = 0; i < burst_len; i++) begin
            case (burst_kind)
               2: chan = hot_a;
               3: chan = i[0] ? hot_b : hot_a;
               default: chan = CHAN_BITS'($urandom_range(31, 0));
            endcase
            if ($urandom_range(4, 0) == 0) begin
               smp = $urandom_range(1, 0) ? 12'hFFF : 12'h000;
            end else begin
               smp = SAMPLE_BITS'($urandom);
            end
            send_sample(chan, smp);
            sent++;
         end
         pause_sender($urandom_range(8, 0));
      end
      req_tvalid <= 1'b0;

      // Drain, then allow for any stray result
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** multichannel_moving_average: PASSED **");
      end else begin
         $display("** multichannel_moving_average: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
hdl/mma_pkg.sv
hdl/multichannel_moving_average.sv
verif/tb_top.sv
